FILE: rtl/core/sms_pkg.sv
// sms_pkg: shared types, codes and constants of the spi master core
`timescale 1ns / 1ps

package sms_pkg;

	// default number of slave select lines
	localparam int unsigned NUM_SELECT_LINES_DEF = 5;

	// field widths
	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned INDEX_W    = 3;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned RATE_W     = 2;
	localparam int unsigned COUNT_W    = 3;
	localparam int unsigned DIV_W      = 7;
	localparam int unsigned BITCNT_W   = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 3;

	// command codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK     = 2'd0,
		OP_SELECT   = 2'd1,
		OP_DESELECT = 2'd2,
		OP_START    = 2'd3
	} opcode_t;

	// status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_SELECTED  = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CPOL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPHA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LSB    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd5;

	// configuration seen by the exchange engine
	typedef struct packed {
		logic              cpol;
		logic              cpha;
		logic              lsb_first;
		logic [RATE_W-1:0] rate;
		logic              double_speed;
	} xfer_cfg_t;

	// per-word view of the exchange engine after the update
	typedef struct packed {
		logic              sck;
		logic              mosi;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rx;
	} xfer_out_t;

	// half period of sck in system ticks
	function automatic logic [DIV_W-1:0] half_period(input logic [RATE_W-1:0] rate,
			input logic dbl);
		logic [DIV_W-1:0] h;
		unique case (rate)
			2'd0: h = 7'd2;
			2'd1: h = 7'd8;
			2'd2: h = 7'd32;
			default: h = 7'd64;
		endcase
		return dbl ? (h >> 1) : h;
	endfunction

endpackage

FILE: rtl/core/sms_if.sv
// sms_if: command and result channel interfaces of the spi master core
`timescale 1ns / 1ps

interface sms_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [2:0] slave_index;
	logic [7:0] tx_byte;
	logic       miso;

	modport source(output valid, opcode, slave_index, tx_byte, miso, input ready);
	modport sink(input valid, opcode, slave_index, tx_byte, miso, output ready);
endinterface

interface sms_res_if #(
	parameter int unsigned NUM_SELECT_LINES = sms_pkg::NUM_SELECT_LINES_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        sck_level;
	logic                        mosi_level;
	logic [NUM_SELECT_LINES-1:0] select_lines_n;
	logic                        transfer_busy;
	logic                        transfer_done;
	logic [7:0]                  rx_byte;
	logic [1:0]                  status;

	modport source(output valid, sck_level, mosi_level, select_lines_n, transfer_busy,
		transfer_done, rx_byte, status, input ready);
	modport sink(input valid, sck_level, mosi_level, select_lines_n, transfer_busy,
		transfer_done, rx_byte, status, output ready);
endinterface

FILE: rtl/core/spi_master_with_slave_select_core.sv
// spi_master_with_slave_select_core: spi master (modes 0 to 3) with slave select lines
// Each command word is one system clock tick of the spi master: it may select or release
// a slave select line, start a full-duplex 8-bit exchange, or just let the running
// exchange advance; the matching result word gives the pin levels (sck, mosi, selects),
// busy and done flags, the last received byte and a status code. One word is taken per
// clock cycle unless the result side stalls; the update is a single registered pass from
// the accepted command into the result register, and a new command is taken while the
// previous result is being taken too. Sck runs at one of four rates, halved with double
// speed, and one exchange spans sixteen half periods after the start word. Configuration
// writes take effect at once and belong to idle periods.
`timescale 1ns / 1ps

module spi_master_with_slave_select_core #(
	parameter int unsigned NUM_SELECT_LINES = sms_pkg::NUM_SELECT_LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sms_pkg::CFG_DATA_W-1:0] cfg_data,
	sms_cmd_if.sink                       cmd,
	sms_res_if.source                     res
);
	import sms_pkg::*;

	typedef struct packed {
		logic                        sck;
		logic                        mosi;
		logic [NUM_SELECT_LINES-1:0] pins;
		logic                        busy;
		logic                        done;
		logic [BYTE_W-1:0]           rx;
		status_t                     status;
	} result_t;

	xfer_cfg_t            cfg_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 step;
	logic                 res_valid_q;
	result_t              res_q;
	xfer_out_t            xout;
	logic [NUM_SELECT_LINES-1:0] pins_next;
	status_t              status;
	opcode_t              opcode;

	assign opcode    = opcode_t'(cmd.opcode);
	assign cmd.ready = !res_valid_q || res.ready;
	assign step      = cmd.valid && cmd.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CPOL:   cfg_q.cpol         <= cfg_data[0];
				REG_CPHA:   cfg_q.cpha         <= cfg_data[0];
				REG_LSB:    cfg_q.lsb_first    <= cfg_data[0];
				REG_RATE:   cfg_q.rate         <= cfg_data[RATE_W-1:0];
				REG_DOUBLE: cfg_q.double_speed <= cfg_data[0];
				REG_COUNT:  count_q            <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sms_select #(
		.NUM_SELECT_LINES(NUM_SELECT_LINES)
	) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.opcode     (opcode),
		.slave_index(cmd.slave_index),
		.slave_count(count_q),
		.pins_next  (pins_next),
		.status     (status)
	);

	sms_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.start   (opcode == OP_START),
		.tx_byte (cmd.tx_byte),
		.miso    (cmd.miso),
		.cfg     (cfg_q),
		.xout    (xout)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			res_valid_q <= cmd.valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q.sck    <= xout.sck;
			res_q.mosi   <= xout.mosi;
			res_q.pins   <= pins_next;
			res_q.busy   <= xout.busy;
			res_q.done   <= xout.done;
			res_q.rx     <= xout.rx;
			res_q.status <= status;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.sck_level      = res_q.sck;
	assign res.mosi_level     = res_q.mosi;
	assign res.select_lines_n = res_q.pins;
	assign res.transfer_busy  = res_q.busy;
	assign res.transfer_done  = res_q.done;
	assign res.rx_byte        = res_q.rx;
	assign res.status         = res_q.status;

endmodule

FILE: rtl/core/sms_select.sv
// sms_select: slave select line register and command checks
`timescale 1ns / 1ps

module sms_select #(
	parameter int unsigned NUM_SELECT_LINES = sms_pkg::NUM_SELECT_LINES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  sms_pkg::opcode_t              opcode,
	input  logic [sms_pkg::INDEX_W-1:0]   slave_index,
	input  logic [sms_pkg::COUNT_W-1:0]   slave_count,
	output logic [NUM_SELECT_LINES-1:0]   pins_next,
	output sms_pkg::status_t              status
);
	import sms_pkg::*;

	logic [NUM_SELECT_LINES-1:0] pins_q;
	logic                        selected_q;
	logic                        selected_next;
	logic                        index_ok;
	logic [NUM_SELECT_LINES-1:0] line_mask;

	// index must be below both the line count in use and the built lines
	assign index_ok  = (slave_index < slave_count)
		&& (32'(slave_index) < NUM_SELECT_LINES);
	assign line_mask = NUM_SELECT_LINES'(1) << slave_index;

	// select / deselect decision
	always_comb begin
		pins_next     = pins_q;
		selected_next = selected_q;
		status        = ST_OK;
		unique case (opcode)
			OP_SELECT: begin
				if (selected_q) begin
					status = ST_SELECTED;
				end else if (!index_ok) begin
					status = ST_BAD_INDEX;
				end else begin
					pins_next     = pins_q & ~line_mask;
					selected_next = 1'b1;
				end
			end
			OP_DESELECT: begin
				if (!index_ok) begin
					status = ST_BAD_INDEX;
				end else begin
					pins_next     = pins_q | line_mask;
					selected_next = 1'b0;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// select state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q     <= '1;
			selected_q <= 1'b0;
		end else if (step) begin
			pins_q     <= pins_next;
			selected_q <= selected_next;
		end
	end

endmodule

FILE: rtl/core/sms_engine.sv
// sms_engine: sck divider, bit counter and shift registers of one byte exchange
`timescale 1ns / 1ps

module sms_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       start,
	input  logic [sms_pkg::BYTE_W-1:0] tx_byte,
	input  logic                       miso,
	input  sms_pkg::xfer_cfg_t         cfg,
	output sms_pkg::xfer_out_t         xout
);
	import sms_pkg::*;

	logic [BYTE_W-1:0]   shift_q, rx_acc_q, received_q;
	logic [BITCNT_W-1:0] bit_count_q;
	logic [DIV_W-1:0]    div_q;
	logic                phase_q, busy_q;

	logic [BYTE_W-1:0]   shift_n, rx_acc_n, received_n;
	logic [BITCNT_W-1:0] bit_count_n;
	logic [DIV_W-1:0]    div_n;
	logic                phase_n, busy_n, done_n;

	// one tick of the exchange
	always_comb begin
		logic [DIV_W-1:0] div_inc;
		logic             leading, do_sample, do_shift, last;
		shift_n     = shift_q;
		rx_acc_n    = rx_acc_q;
		received_n  = received_q;
		bit_count_n = bit_count_q;
		div_n       = div_q;
		phase_n     = phase_q;
		busy_n      = busy_q;
		done_n      = 1'b0;
		div_inc     = div_q + DIV_W'(1);
		leading     = !bit_count_q[0];
		do_sample   = 1'b0;
		do_shift    = 1'b0;
		last        = (bit_count_q == '1);

		if (start && !busy_q) begin
			// load a new exchange; the divider starts counting on the next tick
			shift_n     = tx_byte;
			rx_acc_n    = '0;
			bit_count_n = '0;
			div_n       = '0;
			phase_n     = cfg.cpol;
			busy_n      = 1'b1;
		end else if (busy_q) begin
			div_n = div_inc;
			if (div_inc >= half_period(cfg.rate, cfg.double_speed)) begin
				div_n       = '0;
				phase_n     = !phase_q;
				bit_count_n = bit_count_q + BITCNT_W'(1);
				if (!cfg.cpha) begin
					do_sample = leading;
					do_shift  = !leading;
				end else begin
					do_sample = !leading;
					do_shift  = (leading && bit_count_q != '0) || last;
				end
				if (do_sample) begin
					rx_acc_n = cfg.lsb_first ? {miso, rx_acc_q[BYTE_W-1:1]}
						: {rx_acc_q[BYTE_W-2:0], miso};
				end
				if (do_shift) begin
					shift_n = cfg.lsb_first ? {1'b0, shift_q[BYTE_W-1:1]}
						: {shift_q[BYTE_W-2:0], 1'b0};
				end
				if (last) begin
					busy_n     = 1'b0;
					received_n = rx_acc_n;
					done_n     = 1'b1;
				end
			end
		end
	end

	// pin view after the tick
	assign xout.sck  = busy_n ? phase_n : cfg.cpol;
	assign xout.mosi = cfg.lsb_first ? shift_n[0] : shift_n[BYTE_W-1];
	assign xout.busy = busy_n;
	assign xout.done = done_n;
	assign xout.rx   = received_n;

	// exchange state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			rx_acc_q    <= '0;
			received_q  <= '0;
			bit_count_q <= '0;
			div_q       <= '0;
			phase_q     <= 1'b0;
			busy_q      <= 1'b0;
		end else if (step) begin
			shift_q     <= shift_n;
			rx_acc_q    <= rx_acc_n;
			received_q  <= received_n;
			bit_count_q <= bit_count_n;
			div_q       <= div_n;
			phase_q     <= phase_n;
			busy_q      <= busy_n;
		end
	end

endmodule

FILE: rtl/core/sms_checker.sv
// sms_checker: port-level assertions for the spi master core, bound to the top level
`timescale 1ns / 1ps

module sms_checker #(
	parameter int unsigned NUM_SELECT_LINES = sms_pkg::NUM_SELECT_LINES_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [NUM_SELECT_LINES-1:0] select_lines_n,
	input logic                        transfer_busy,
	input logic                        transfer_done
);

	// a stalled result word stays offered
	property p_res_hold;
		@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid;
	endproperty
	a_res_hold: assert property (p_res_hold) else $error("result word dropped while stalled");

	// the final edge clears busy in the same word
	property p_done_not_busy;
		@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(transfer_done && transfer_busy);
	endproperty
	a_done_not_busy: assert property (p_done_not_busy)
		else $error("done reported while still busy");

	// a stalled result word keeps its pins and flags
	property p_res_stable;
		@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable({select_lines_n, transfer_busy, transfer_done});
	endproperty
	a_res_stable: assert property (p_res_stable) else $error("result word changed while stalled");

endmodule

bind spi_master_with_slave_select_core sms_checker #(
	.NUM_SELECT_LINES(NUM_SELECT_LINES)
) u_sms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.select_lines_n(res.select_lines_n),
	.transfer_busy (res.transfer_busy),
	.transfer_done (res.transfer_done)
);

FILE: bench/spi_master_with_slave_select_core_test.sv
// spi_master_with_slave_select_core_test: self-checking bench for the spi master core
`timescale 1ns / 1ps

module spi_master_with_slave_select_core_test;
	import sms_pkg::*;

	localparam int unsigned LINES = NUM_SELECT_LINES_DEF;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned HOLD_OFF = 400;

	// one result word as the pins and flags show it
	typedef struct packed {
		logic             sck;
		logic             mosi;
		logic [LINES-1:0] sel_n;
		logic             busy;
		logic             done;
		logic [7:0]       rx;
		status_t          status;
	} pin_word_t;

	// one full register setting
	typedef struct packed {
		logic       cpol;
		logic       cpha;
		logic       lsb;
		logic [1:0] rate;
		logic       dbl;
		logic [2:0] lines;
	} spi_setup_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sms_cmd_if cmd_ch();
	sms_res_if #(.NUM_SELECT_LINES(LINES)) res_ch();

	spi_master_with_slave_select_core #(.NUM_SELECT_LINES(LINES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and the engine state
	logic       cfg_cpol, cfg_cpha, cfg_lsb, cfg_dbl;
	logic [1:0] cfg_rate;
	logic [2:0] cfg_lines;
	logic [7:0] m_shift, m_rx_acc, m_rx;
	logic [3:0] m_edges;
	logic [6:0] m_div;
	logic       m_sck, m_busy, m_selected;
	logic [LINES-1:0] m_pins;

	pin_word_t pending_pins[$];
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	// pacing of the sender and stalling of the receiver
	bit pace_on = 1'b0;
	int unsigned gap_max = 1;
	int unsigned burst_left = 0;
	int unsigned stall_mode = 0;
	int unsigned hold_cycles = 0;

	function automatic logic [2:0] rand_idx();
		return 3'($urandom_range(0, 7));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [6:0] sck_half_ticks();
		logic [6:0] h;
		case (cfg_rate)
			2'd0: h = 7'd2;
			2'd1: h = 7'd8;
			2'd2: h = 7'd32;
			default: h = 7'd64;
		endcase
		return cfg_dbl ? (h >> 1) : h;
	endfunction

	function automatic bit line_usable(input logic [2:0] idx);
		return idx < cfg_lines && idx < LINES;
	endfunction

	function automatic void shift_tx();
		m_shift = cfg_lsb ? (m_shift >> 1) : (m_shift << 1);
	endfunction

	function automatic void shift_rx(input logic bit_in);
		m_rx_acc = cfg_lsb ? {bit_in, m_rx_acc[7:1]} : {m_rx_acc[6:0], bit_in};
	endfunction

	function automatic void reset_engine();
		m_shift = '0;
		m_rx_acc = '0;
		m_rx = '0;
		m_edges = '0;
		m_div = '0;
		m_sck = 1'b0;
		m_busy = 1'b0;
		m_selected = 1'b0;
		m_pins = '1;
		cfg_cpol = 1'b0;
		cfg_cpha = 1'b0;
		cfg_lsb = 1'b0;
		cfg_rate = '0;
		cfg_dbl = 1'b0;
		cfg_lines = '0;
	endfunction

	// one tick of the master: command, then divider and shifter
	function automatic pin_word_t predict_pins(input opcode_t op, input logic [2:0] idx,
			input logic [7:0] tx, input logic miso);
		pin_word_t w;
		logic was_busy;
		logic leading;
		w.status = ST_OK;
		w.done = 1'b0;
		was_busy = m_busy;
		case (op)
			OP_SELECT: begin
				if (m_selected)
					w.status = ST_SELECTED;
				else if (!line_usable(idx))
					w.status = ST_BAD_INDEX;
				else begin
					m_pins[idx] = 1'b0;
					m_selected = 1'b1;
				end
			end
			OP_DESELECT: begin
				if (!line_usable(idx))
					w.status = ST_BAD_INDEX;
				else begin
					m_pins[idx] = 1'b1;
					m_selected = 1'b0;
				end
			end
			OP_START: begin
				if (!was_busy) begin
					m_shift = tx;
					m_rx_acc = '0;
					m_edges = '0;
					m_div = '0;
					m_sck = cfg_cpol;
					m_busy = 1'b1;
				end
			end
			default: ;
		endcase
		// sck edge once the half period has run out
		if (was_busy) begin
			m_div = m_div + 7'd1;
			if (m_div >= sck_half_ticks()) begin
				leading = ~m_edges[0];
				m_div = '0;
				m_sck = ~m_sck;
				if (!cfg_cpha) begin
					if (leading) shift_rx(miso);
					else shift_tx();
				end else begin
					if (leading) begin
						if (m_edges != 0) shift_tx();
					end else
						shift_rx(miso);
				end
				m_edges = m_edges + 4'd1;
				if (m_edges == 0) begin
					if (cfg_cpha) shift_tx();
					m_busy = 1'b0;
					m_rx = m_rx_acc;
					w.done = 1'b1;
				end
			end
		end
		w.sck = m_busy ? m_sck : cfg_cpol;
		w.mosi = cfg_lsb ? m_shift[0] : m_shift[7];
		w.sel_n = m_pins;
		w.busy = m_busy;
		w.rx = m_rx;
		return w;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// result checking, then prediction of the word accepted at this edge
	always @(posedge clk) begin
		pin_word_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_pins.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = pending_pins.pop_front();
					check_field("sck_level", 32'(want.sck), 32'(res_ch.sck_level));
					check_field("mosi_level", 32'(want.mosi), 32'(res_ch.mosi_level));
					check_field("select_lines_n", 32'(want.sel_n),
						32'(res_ch.select_lines_n));
					check_field("transfer_busy", 32'(want.busy), 32'(res_ch.transfer_busy));
					check_field("transfer_done", 32'(want.done), 32'(res_ch.transfer_done));
					check_field("rx_byte", 32'(want.rx), 32'(res_ch.rx_byte));
					check_field("status", 32'(want.status), 32'(res_ch.status));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				pending_pins.push_back(predict_pins(opcode_t'(cmd_ch.opcode),
					cmd_ch.slave_index, cmd_ch.tx_byte, cmd_ch.miso));
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// receiver: long hold-off when asked, otherwise its own stall pattern
	initial begin
		int unsigned beat;
		beat = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			beat++;
			if (hold_cycles != 0) begin
				hold_cycles--;
				res_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					default: res_ch.ready <= ((beat % 7) < 4);
				endcase
			end
		end
	end

	// offer one command word and wait for it to be taken; called at a falling edge
	task automatic send_word(input opcode_t op, input logic [2:0] idx, input logic [7:0] tx);
		int unsigned gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.slave_index <= idx;
		cmd_ch.tx_byte <= tx;
		cmd_ch.miso <= 1'($urandom_range(0, 1));
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
		if (pace_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, gap_max);
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end else
				burst_left--;
		end
	endtask

	// let a running exchange end and every result come back
	task automatic drain();
		while (m_busy) send_word(OP_TICK, rand_idx(), rand_byte());
		cmd_ch.valid <= 1'b0;
		while (pending_pins.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] d);
		cfg_index <= r;
		cfg_data <= d;
		@(negedge clk);
	endtask

	// write all six registers while the core is idle
	task automatic load_setup(input spi_setup_t s);
		drain();
		cfg_we <= 1'b1;
		write_reg(REG_CPOL, CFG_DATA_W'(s.cpol));
		write_reg(REG_CPHA, CFG_DATA_W'(s.cpha));
		write_reg(REG_LSB, CFG_DATA_W'(s.lsb));
		write_reg(REG_RATE, CFG_DATA_W'(s.rate));
		write_reg(REG_DOUBLE, CFG_DATA_W'(s.dbl));
		write_reg(REG_COUNT, s.lines);
		cfg_we <= 1'b0;
		cfg_cpol = s.cpol;
		cfg_cpha = s.cpha;
		cfg_lsb = s.lsb;
		cfg_rate = s.rate;
		cfg_dbl = s.dbl;
		cfg_lines = s.lines;
		@(negedge clk);
	endtask

	function automatic spi_setup_t random_setup();
		spi_setup_t s;
		int unsigned pick;
		s.cpol = 1'($urandom_range(0, 1));
		s.cpha = 1'($urandom_range(0, 1));
		s.lsb = 1'($urandom_range(0, 1));
		s.dbl = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 19);
		s.rate = (pick < 12) ? 2'd0 : (pick < 19) ? 2'd1 : 2'd2;
		if (s.rate == 2'd2) s.dbl = 1'b1;
		s.lines = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, LINES));
		return s;
	endfunction

	function automatic void random_pacing();
		pace_on = ($urandom_range(0, 3) != 0);
		gap_max = $urandom_range(1, 6);
		stall_mode = $urandom_range(0, 2);
	endfunction

	// select a line, swap one byte, release the line
	task automatic run_exchange(input logic [2:0] line, input logic [7:0] tx);
		send_word(OP_SELECT, line, rand_byte());
		send_word(OP_START, rand_idx(), tx);
		while (m_busy) send_word(OP_TICK, rand_idx(), rand_byte());
		send_word(OP_DESELECT, line, rand_byte());
	endtask

	// mostly whole select/exchange/release sequences, with noise in between and inside
	task automatic random_words(input int unsigned n_items);
		int unsigned sent;
		int unsigned usable;
		logic [2:0] line;
		sent = 0;
		usable = (cfg_lines < LINES) ? cfg_lines : LINES;
		while (sent < n_items) begin
			if (usable != 0 && $urandom_range(0, 9) < 8) begin
				line = 3'($urandom_range(0, usable - 1));
				send_word(OP_SELECT, line, rand_byte());
				send_word(OP_START, rand_idx(), rand_byte());
				sent += 2;
				while (m_busy) begin
					if ($urandom_range(0, 15) == 0)
						send_word(opcode_t'($urandom_range(0, 3)), rand_idx(), rand_byte());
					else
						send_word(OP_TICK, rand_idx(), rand_byte());
					sent++;
				end
				send_word(OP_DESELECT, line, rand_byte());
				sent++;
			end else begin
				send_word(opcode_t'($urandom_range(0, 3)), rand_idx(), rand_byte());
				sent++;
			end
		end
	endtask

	// every command and status, start while busy, select while selected
	task automatic test_commands();
		load_setup('{cpol: 1'b0, cpha: 1'b0, lsb: 1'b0, rate: 2'd0, dbl: 1'b1, lines: 3'd5});
		send_word(OP_TICK, 3'd0, 8'h00);
		send_word(OP_SELECT, 3'd4, 8'h00);
		send_word(OP_SELECT, 3'd1, 8'h00);
		send_word(OP_DESELECT, 3'd7, 8'h00);
		send_word(OP_DESELECT, 3'd5, 8'h00);
		send_word(OP_DESELECT, 3'd4, 8'h00);
		send_word(OP_SELECT, 3'd6, 8'h00);
		send_word(OP_SELECT, 3'd0, 8'h00);
		send_word(OP_START, 3'd0, 8'hFF);
		send_word(OP_START, 3'd0, 8'h00);
		send_word(OP_DESELECT, 3'd0, 8'h00);
		send_word(OP_SELECT, 3'd3, 8'h00);
		drain();
	endtask

	// line count at zero and above the number of pins, with every mode bit set
	task automatic test_line_limits();
		load_setup('{cpol: 1'b1, cpha: 1'b1, lsb: 1'b1, rate: 2'd0, dbl: 1'b0, lines: 3'd0});
		send_word(OP_SELECT, 3'd0, 8'h00);
		send_word(OP_DESELECT, 3'd0, 8'h00);
		run_exchange(3'd0, 8'h00);
		load_setup('{cpol: 1'b1, cpha: 1'b1, lsb: 1'b1, rate: 2'd0, dbl: 1'b0, lines: 3'd7});
		send_word(OP_SELECT, 3'd5, 8'h00);
		send_word(OP_SELECT, 3'd6, 8'h00);
		send_word(OP_SELECT, 3'd7, 8'h00);
		run_exchange(3'd4, 8'hFF);
	endtask

	// all eight combinations of polarity, phase and bit order
	task automatic test_modes();
		spi_setup_t s;
		for (int m = 0; m < 8; m++) begin
			s.cpol = m[0];
			s.cpha = m[1];
			s.lsb = m[2];
			s.rate = 2'd0;
			s.dbl = 1'($urandom_range(0, 1));
			s.lines = 3'(LINES);
			load_setup(s);
			random_pacing();
			run_exchange(3'($urandom_range(0, LINES - 1)), rand_byte());
		end
	endtask

	// slowest serial clock, then rate 2 halved by double speed
	task automatic test_slow_rates();
		load_setup('{cpol: 1'b1, cpha: 1'b0, lsb: 1'b0, rate: 2'd3, dbl: 1'b0, lines: 3'd1});
		pace_on = 1'b0;
		stall_mode = 0;
		run_exchange(3'd0, rand_byte());
		load_setup('{cpol: 1'b0, cpha: 1'b1, lsb: 1'b1, rate: 2'd2, dbl: 1'b1, lines: 3'd2});
		stall_mode = 1;
		run_exchange(3'd1, rand_byte());
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_back_pressure();
		load_setup('{cpol: 1'b0, cpha: 1'b1, lsb: 1'b0, rate: 2'd0, dbl: 1'b1, lines: 3'd5});
		pace_on = 1'b0;
		stall_mode = 0;
		hold_cycles = HOLD_OFF;
		random_words(80);
	endtask

	// random settings, pacing and command streams
	task automatic test_random();
		for (int p = 0; p < 4; p++) begin
			load_setup(random_setup());
			random_pacing();
			random_words(60);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_TICK;
		cmd_ch.slave_index = '0;
		cmd_ch.tx_byte = '0;
		cmd_ch.miso = 1'b0;
		reset_engine();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_commands();
		test_line_limits();
		test_modes();
		test_slow_rates();
		test_back_pressure();
		test_random();

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
